// ===== sv/stq_pkg.sv =====
// Shared constants, command codes and types of the sorted timer queue.
`timescale 1ns / 1ps

package stq_pkg;

    localparam int SLOTS      = 16;
    localparam int TIME_BITS  = 32;
    localparam int ID_W       = 4;
    localparam int ID_COUNT   = 16;
    localparam int DELAY_W    = 32;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int LEN_W      = $clog2(SLOTS + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int IN_TDATA_W  = ((ID_W + DELAY_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((STATUS_W + ID_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP  = 2'd2;

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACTIVE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STOPPED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd3;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [ID_W-1:0]    id;
        logic [DELAY_W-1:0] delay;
    } t_cmd;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             busy;
    } t_back_stat;

endpackage

// ===== sv/stq_front.sv =====
// Front end: accepts input transactions, classifies them and queues commands.
`timescale 1ns / 1ps

module stq_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [stq_pkg::KIND_W-1:0]   i_kind,
    input  logic [stq_pkg::ID_W-1:0]     i_timer_id,
    input  logic [stq_pkg::DELAY_W-1:0]  i_delay,
    output logic                         o_cmd_valid,
    input  logic                         i_cmd_ready,
    output stq_pkg::t_cmd                o_cmd
);

    stq_pkg::t_cmd                r_fifo [stq_pkg::FIFO_DEPTH];
    logic [stq_pkg::FIFO_AW-1:0]  r_wr_ptr;
    logic [stq_pkg::FIFO_AW-1:0]  r_rd_ptr;
    logic [stq_pkg::FIFO_AW:0]    r_count;
    logic [stq_pkg::FIFO_AW:0]    n_count;
    stq_pkg::t_cmd                w_cmd;
    logic                         w_push;
    logic                         w_pop;

    always_comb begin
        w_cmd.id    = i_timer_id;
        w_cmd.delay = i_delay;
        case (i_kind)
            stq_pkg::KIND_TICK:  w_cmd.op = stq_pkg::OP_TICK;
            stq_pkg::KIND_START: w_cmd.op = stq_pkg::OP_START;
            stq_pkg::KIND_STOP:  w_cmd.op = stq_pkg::OP_STOP;
            default:             w_cmd.op = stq_pkg::OP_NOP;
        endcase
    end

    assign o_ready     = (r_count != (stq_pkg::FIFO_AW + 1)'(stq_pkg::FIFO_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_fifo[r_rd_ptr];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// ===== sv/stq_back.sv =====
// Back end: sorted cell array, tick count, command execution and result register.
`timescale 1ns / 1ps

module stq_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  stq_pkg::t_cmd                 i_cmd,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [stq_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_exp_valid,
    output logic [stq_pkg::ID_W-1:0]      o_exp_id,
    output logic                          o_last,
    output stq_pkg::t_back_stat           o_stat
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_TICK = 1'b1;

    stq_pkg::t_time                 r_exp [stq_pkg::SLOTS];
    logic [stq_pkg::ID_W-1:0]       r_tid [stq_pkg::SLOTS];
    stq_pkg::t_time                 r_time, n_time;
    logic [stq_pkg::LEN_W-1:0]      r_len, n_len;
    logic [stq_pkg::ID_COUNT-1:0]   r_active, n_active;
    logic                           r_state, n_state;
    logic                           r_out_valid, n_out_valid;
    logic [stq_pkg::STATUS_W-1:0]   r_out_status, n_out_status;
    logic                           r_out_xv, n_out_xv;
    logic [stq_pkg::ID_W-1:0]       r_out_xid, n_out_xid;
    logic                           r_out_last, n_out_last;

    stq_pkg::t_time                 w_new_exp;
    stq_pkg::t_time                 w_delay;
    stq_pkg::t_time                 w_prev_exp [stq_pkg::SLOTS];
    logic [stq_pkg::ID_W-1:0]       w_prev_tid [stq_pkg::SLOTS];
    stq_pkg::t_time                 w_nxt_exp  [stq_pkg::SLOTS];
    logic [stq_pkg::ID_W-1:0]       w_nxt_tid  [stq_pkg::SLOTS];
    logic [stq_pkg::SLOTS-1:0]      w_lt;
    logic [stq_pkg::SLOTS-1:0]      w_lt_sh;
    logic [stq_pkg::SLOTS-1:0]      w_after;
    logic                           w_out_free;
    logic                           w_take;
    logic                           w_head_due;
    logic                           w_next_due;
    logic                           w_insert;
    logic                           w_remove;
    logic                           w_pop;

    assign w_out_free  = !r_out_valid || i_ready;
    assign o_cmd_ready = (r_state == S_IDLE) && w_out_free;
    assign w_take      = i_cmd_valid && o_cmd_ready;
    assign w_delay     = stq_pkg::TIME_BITS'(i_cmd.delay);
    assign w_new_exp   = r_time + w_delay;
    assign w_head_due  = (r_len != '0) && (r_exp[0] <= r_time);
    assign w_next_due  = (r_len > stq_pkg::LEN_W'(1)) && (r_exp[1] <= r_time);

    always_comb begin
        logic [stq_pkg::SLOTS-1:0] v_match;
        logic                      v_acc;
        logic                      v_valid;
        v_acc = 1'b0;
        for (int i = 0; i < stq_pkg::SLOTS; i++) begin
            v_valid    = (stq_pkg::LEN_W'(i) < r_len);
            w_lt[i]    = v_valid && (r_exp[i] < w_new_exp);
            v_match[i] = v_valid && (r_tid[i] == i_cmd.id);
            v_acc      = v_acc | v_match[i];
            w_after[i] = v_acc;
        end
        w_lt_sh = {w_lt[stq_pkg::SLOTS-2:0], 1'b1};
        w_prev_exp[0] = w_new_exp;
        w_prev_tid[0] = i_cmd.id;
        for (int i = 1; i < stq_pkg::SLOTS; i++) begin
            w_prev_exp[i] = r_exp[i-1];
            w_prev_tid[i] = r_tid[i-1];
        end
        for (int i = 0; i < stq_pkg::SLOTS - 1; i++) begin
            w_nxt_exp[i] = r_exp[i+1];
            w_nxt_tid[i] = r_tid[i+1];
        end
        w_nxt_exp[stq_pkg::SLOTS-1] = r_exp[stq_pkg::SLOTS-1];
        w_nxt_tid[stq_pkg::SLOTS-1] = r_tid[stq_pkg::SLOTS-1];
    end

    always_comb begin
        n_time       = r_time;
        n_len        = r_len;
        n_active     = r_active;
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_xv     = r_out_xv;
        n_out_xid    = r_out_xid;
        n_out_last   = r_out_last;
        w_insert     = 1'b0;
        w_remove     = 1'b0;
        w_pop        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_out_xv   = 1'b0;
                    n_out_xid  = '0;
                    n_out_last = 1'b1;
                    case (i_cmd.op)
                        stq_pkg::OP_TICK: begin
                            n_time  = r_time + 1'b1;
                            n_state = S_TICK;
                        end
                        stq_pkg::OP_START: begin
                            n_out_valid = 1'b1;
                            if (r_active[i_cmd.id]) begin
                                n_out_status = stq_pkg::ST_ACTIVE;
                            end else if (w_delay == '0) begin
                                n_out_status = stq_pkg::ST_ZERO;
                            end else if (r_len >= stq_pkg::LEN_W'(stq_pkg::SLOTS)) begin
                                n_out_status = stq_pkg::ST_ACTIVE;
                            end else begin
                                n_out_status       = stq_pkg::ST_OK;
                                w_insert           = 1'b1;
                                n_len              = r_len + 1'b1;
                                n_active[i_cmd.id] = 1'b1;
                            end
                        end
                        stq_pkg::OP_STOP: begin
                            n_out_valid = 1'b1;
                            if (!r_active[i_cmd.id]) begin
                                n_out_status = stq_pkg::ST_STOPPED;
                            end else begin
                                n_out_status       = stq_pkg::ST_OK;
                                w_remove           = 1'b1;
                                n_len              = r_len - 1'b1;
                                n_active[i_cmd.id] = 1'b0;
                            end
                        end
                        default: begin
                            n_out_valid  = 1'b1;
                            n_out_status = stq_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_TICK: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = stq_pkg::ST_OK;
                    if (w_head_due) begin
                        w_pop              = 1'b1;
                        n_len              = r_len - 1'b1;
                        n_active[r_tid[0]] = 1'b0;
                        n_out_xv           = 1'b1;
                        n_out_xid          = r_tid[0];
                        n_out_last         = !w_next_due;
                        if (!w_next_due) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_out_xv   = 1'b0;
                        n_out_xid  = '0;
                        n_out_last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_len       <= '0;
            r_active    <= '0;
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_time      <= n_time;
            r_len       <= n_len;
            r_active    <= n_active;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_xv     <= n_out_xv;
        r_out_xid    <= n_out_xid;
        r_out_last   <= n_out_last;
        for (int i = 0; i < stq_pkg::SLOTS; i++) begin
            if (w_insert) begin
                if (!w_lt[i]) begin
                    r_exp[i] <= w_lt_sh[i] ? w_new_exp : w_prev_exp[i];
                    r_tid[i] <= w_lt_sh[i] ? i_cmd.id : w_prev_tid[i];
                end
            end else if (w_pop || (w_remove && w_after[i])) begin
                r_exp[i] <= w_nxt_exp[i];
                r_tid[i] <= w_nxt_tid[i];
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_out_status;
    assign o_exp_valid = r_out_xv;
    assign o_exp_id    = r_out_xid;
    assign o_last      = r_out_last;
    assign o_stat.len  = r_len;
    assign o_stat.busy = (r_state == S_TICK);

endmodule

// ===== sv/sorted_timer_queue_unit.sv =====
// Top level of the sorted timer queue: front end, command queue and back end.
//
//  channel  | dir | tdata                               | tuser           | tlast
//  s_axis   | in  | [3:0] timer_id, [35:4] delay        | [1:0] kind      | -
//  m_axis   | out | [1:0] status, [5:2] expired_id      | [0] exp. valid  | last result
//
// Start, stop and unused kinds are answered in the cycle after they are taken.
// A tick advances the count, then gives one result per expired timer (a single
// one if none expire); the cell array moves one step per cycle while not stalled.
// The four-entry command queue keeps accepting while the back end works.
// Reset (synchronous, active low) clears the count, the queue and the active mask.
// A stalled result register holds the back end; a full command queue holds s_axis.
`timescale 1ns / 1ps

module sorted_timer_queue_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [stq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // timer_id, delay
    input  logic [stq_pkg::KIND_W-1:0]         s_axis_tuser,   // kind
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [stq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // status, expired_id
    output logic [0:0]                         m_axis_tuser,   // expired_valid
    output logic                               m_axis_tlast
);

    logic                           w_cmd_valid;
    logic                           w_cmd_ready;
    stq_pkg::t_cmd                  w_cmd;
    stq_pkg::t_back_stat            w_stat;
    logic [stq_pkg::STATUS_W-1:0]   w_status;
    logic [stq_pkg::ID_W-1:0]       w_exp_id;
    logic                           w_exp_valid;

    stq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_timer_id  (s_axis_tdata[stq_pkg::ID_W-1:0]),
        .i_delay     (s_axis_tdata[stq_pkg::ID_W +: stq_pkg::DELAY_W]),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    stq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_status    (w_status),
        .o_exp_valid (w_exp_valid),
        .o_exp_id    (w_exp_id),
        .o_last      (m_axis_tlast),
        .o_stat      (w_stat)
    );

    assign m_axis_tdata = {{(stq_pkg::OUT_TDATA_W - stq_pkg::STATUS_W - stq_pkg::ID_W){1'b0}},
                           w_exp_id, w_status};
    assign m_axis_tuser = w_exp_valid;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.len <= stq_pkg::LEN_W'(stq_pkg::SLOTS))
        else $error("queue length beyond slot count");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_valid && w_cmd_ready && w_cmd.op == stq_pkg::OP_TICK) |=> w_stat.busy)
        else $error("tick command did not start expiry scan");

    a_plain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("result without expiry not marked last");

endmodule
